>>> rtl/rsfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsfp_pkg;

    // Frame header bytes
    localparam logic [7:0] HDR_A0 = 8'h55;
    localparam logic [7:0] HDR_A1 = 8'hAA;
    localparam logic [7:0] HDR_B  = 8'h59;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STRENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE = 2'd2;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned SCALE_W    = 4;
    localparam int unsigned DIST_W     = 16;
    localparam int unsigned PROD_W     = DIST_W + SCALE_W;

    localparam logic [15:0]        RST_MIN_STRENGTH   = 16'd20;
    localparam logic [15:0]        RST_MAX_DISTANCE   = 16'd7500;
    localparam logic [SCALE_W-1:0] RST_DISTANCE_SCALE = 4'd10;

    // Small register queues
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    // One frame result: raw distance or scaled distance, and its source parser
    typedef struct packed {
        logic              source;
        logic [DIST_W-1:0] value;
    } t_item;

endpackage

`default_nettype wire

>>> rtl/range_sensor_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Range sensor frame parser: two byte-stream frame parsers side by side.
// Input channel: drive i_rx_byte and raise i_push; the byte is taken at a
// clock edge with i_push high and o_full low. One byte per cycle is sustained while o_full is low.
// Result channel: while o_empty is low, o_distance/o_source show the oldest
// result; raise i_pop to take it. o_source is 0 for a 0x55 0xAA frame and
// 1 for a 0x59 0x59 frame (that one wins when both close on one byte).
// Path: a result passes through the middle queue, then the scale multiplier
// register, then the output queue, before it shows on the output ports.
// Throughput: one byte per cycle while o_full is low, set by the parser front end.
// Stall: results wait in a four-entry output queue; once it and the four-entry
// middle queue fill, o_full rises and input bytes hold off.
// Config: write i_cfg_data to register i_cfg_index when i_cfg_we is high
// (0 min strength, 1 max distance, 2 distance scale); write only while idle.
// Reset (synchronous, i_rst_n low): both parsers hunt for a header, the
// queues empty, and the registers return to 20, 7500 and 10.
module range_sensor_frame_parser (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    output logic                                  o_full,
    input  wire logic [7:0]                       i_rx_byte,
    output logic                                  o_empty,
    input  wire logic                             i_pop,
    output logic [15:0]                           o_distance,
    output logic                                  o_source,
    input  wire logic                             i_cfg_we,
    input  wire logic [rsfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rsfp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [15:0]                  r_min_strength;
    logic [15:0]                  r_max_distance;
    logic [rsfp_pkg::SCALE_W-1:0] r_distance_scale;

    logic                         in_take;
    logic                         front_push;
    rsfp_pkg::t_item              front_item;
    rsfp_pkg::t_item              mid_item;
    logic                         mid_empty;
    logic                         mid_pop;
    logic [rsfp_pkg::QCNT_W-1:0]  mid_count;
    rsfp_pkg::t_item              out_item;

    // Configuration registers; an unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_strength   <= rsfp_pkg::RST_MIN_STRENGTH;
            r_max_distance   <= rsfp_pkg::RST_MAX_DISTANCE;
            r_distance_scale <= rsfp_pkg::RST_DISTANCE_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rsfp_pkg::CFG_MIN_STRENGTH:   r_min_strength   <= i_cfg_data;
                rsfp_pkg::CFG_MAX_DISTANCE:   r_max_distance   <= i_cfg_data;
                rsfp_pkg::CFG_DISTANCE_SCALE:
                    r_distance_scale <= i_cfg_data[rsfp_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold off input whenever the middle queue has no room for a result
    assign o_full  = (mid_count == rsfp_pkg::QCNT_W'(rsfp_pkg::QDEPTH));
    assign in_take = i_push && !o_full;

    rsfp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_take),
        .i_byte         (i_rx_byte),
        .i_min_strength (r_min_strength),
        .o_push         (front_push),
        .o_item         (front_item)
    );

    rsfp_fifo u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_item),
        .i_pop   (mid_pop),
        .o_data  (mid_item),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    rsfp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mid_empty      (mid_empty),
        .i_mid_item       (mid_item),
        .o_mid_pop        (mid_pop),
        .i_max_distance   (r_max_distance),
        .i_distance_scale (r_distance_scale),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_item           (out_item)
    );

    assign o_distance = out_item.value;
    assign o_source   = out_item.source;

endmodule

`default_nettype wire

>>> rtl/rsfp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rsfp_fifo (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire rsfp_pkg::t_item              i_data,
    input  wire logic                         i_pop,
    output rsfp_pkg::t_item                   o_data,
    output logic                              o_empty,
    output logic [rsfp_pkg::QCNT_W-1:0]       o_count
);

    rsfp_pkg::t_item                r_mem [rsfp_pkg::QDEPTH];
    logic [rsfp_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [rsfp_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [rsfp_pkg::QCNT_W-1:0]    r_count;
    logic [rsfp_pkg::QCNT_W-1:0]    n_count;
    logic                           do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

>>> rtl/rsfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rsfp_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic [15:0] i_min_strength,
    output logic             o_push,
    output rsfp_pkg::t_item  o_item
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_HDR2 = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [7:0] SUM_A_INIT = 8'(rsfp_pkg::HDR_A0 + rsfp_pkg::HDR_A1);
    localparam logic [7:0] SUM_B_INIT = 8'(rsfp_pkg::HDR_B + rsfp_pkg::HDR_B);

    // Parser A state
    logic [1:0]  r_a_phase, n_a_phase;
    logic [2:0]  r_a_count, n_a_count;
    logic [7:0]  r_a_sum;
    logic [7:0]  r_a_check;
    logic [15:0] r_a_dist;

    // Parser B state
    logic [1:0]  r_b_phase, n_b_phase;
    logic [3:0]  r_b_count, n_b_count;
    logic [7:0]  r_b_sum;
    logic [15:0] r_b_dist;
    logic [15:0] r_b_str;

    logic a_hit;
    logic b_hit;

    always_comb begin
        n_a_phase = r_a_phase;
        n_a_count = r_a_count;
        unique case (r_a_phase)
            PH_HDR2: begin
                n_a_phase = (i_byte == rsfp_pkg::HDR_A1) ? PH_BODY : PH_HUNT;
                n_a_count = '0;
            end
            PH_BODY: begin
                if (r_a_count == 3'd6) begin
                    n_a_phase = PH_HUNT;
                    n_a_count = '0;
                end else begin
                    n_a_count = r_a_count + 3'd1;
                end
            end
            default: begin
                n_a_phase = (i_byte == rsfp_pkg::HDR_A0) ? PH_HDR2 : PH_HUNT;
                n_a_count = '0;
            end
        endcase
    end

    always_comb begin
        n_b_phase = r_b_phase;
        n_b_count = r_b_count;
        unique case (r_b_phase)
            PH_HDR2: begin
                if (i_byte == rsfp_pkg::HDR_B) begin
                    n_b_phase = PH_BODY;
                    n_b_count = 4'd2;
                end else begin
                    n_b_phase = PH_HUNT;
                    n_b_count = '0;
                end
            end
            PH_BODY: begin
                if (r_b_count >= 4'd8) begin
                    n_b_phase = PH_HUNT;
                    n_b_count = '0;
                end else begin
                    n_b_count = r_b_count + 4'd1;
                end
            end
            default: begin
                if (i_byte == rsfp_pkg::HDR_B) begin
                    n_b_phase = PH_HDR2;
                    n_b_count = 4'd1;
                end else begin
                    n_b_phase = PH_HUNT;
                    n_b_count = '0;
                end
            end
        endcase
    end

    assign a_hit = i_valid && (r_a_phase == PH_BODY) && (r_a_count == 3'd6)
                   && (r_a_sum == r_a_check);
    assign b_hit = i_valid && (r_b_phase == PH_BODY) && (r_b_count >= 4'd8)
                   && (r_b_sum == i_byte) && (r_b_str > i_min_strength);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_phase <= PH_HUNT;
            r_a_count <= '0;
            r_b_phase <= PH_HUNT;
            r_b_count <= '0;
        end else if (i_valid) begin
            r_a_phase <= n_a_phase;
            r_a_count <= n_a_count;
            r_b_phase <= n_b_phase;
            r_b_count <= n_b_count;
        end
    end

    // Payload capture and running checksums
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            if (r_a_phase == PH_HDR2) begin
                r_a_sum <= SUM_A_INIT;
            end else if (r_a_phase == PH_BODY) begin
                if (r_a_count < 3'd5) begin
                    r_a_sum <= r_a_sum + i_byte;
                end
                if (r_a_count == 3'd5) begin
                    r_a_check <= i_byte;
                end
                if (r_a_count == 3'd3) begin
                    r_a_dist[15:8] <= i_byte;
                end
                if (r_a_count == 3'd4) begin
                    r_a_dist[7:0] <= i_byte;
                end
            end

            if (r_b_phase == PH_HDR2) begin
                r_b_sum <= SUM_B_INIT;
            end else if (r_b_phase == PH_BODY && r_b_count < 4'd8) begin
                r_b_sum <= r_b_sum + i_byte;
                case (r_b_count)
                    4'd2:    r_b_dist[7:0]  <= i_byte;
                    4'd3:    r_b_dist[15:8] <= i_byte;
                    4'd4:    r_b_str[7:0]   <= i_byte;
                    4'd5:    r_b_str[15:8]  <= i_byte;
                    default: ;
                endcase
            end
        end
    end

    // Parser B wins when both close a good frame on the same byte
    assign o_push       = a_hit || b_hit;
    assign o_item.source = b_hit;
    assign o_item.value  = b_hit ? r_b_dist : r_a_dist;

endmodule

`default_nettype wire

>>> rtl/rsfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rsfp_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_mid_empty,
    input  wire rsfp_pkg::t_item                i_mid_item,
    output logic                                o_mid_pop,
    input  wire logic [15:0]                    i_max_distance,
    input  wire logic [rsfp_pkg::SCALE_W-1:0]   i_distance_scale,
    input  wire logic                           i_pop,
    output logic                                o_empty,
    output rsfp_pkg::t_item                     o_item
);

    logic                          r_prod_valid;
    logic                          r_prod_src;
    logic [rsfp_pkg::PROD_W-1:0]   r_prod;
    logic [rsfp_pkg::QCNT_W-1:0]   out_count;
    logic [rsfp_pkg::QCNT_W:0]     used;
    rsfp_pkg::t_item               clamped;

    // Reserve a slot for the product in flight
    assign used      = {1'b0, out_count} + {{rsfp_pkg::QCNT_W{1'b0}}, r_prod_valid};
    assign o_mid_pop = !i_mid_empty && (used < (rsfp_pkg::QCNT_W+1)'(rsfp_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= o_mid_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_prod_src <= i_mid_item.source;
            r_prod     <= {{rsfp_pkg::SCALE_W{1'b0}}, i_mid_item.value}
                          * {{rsfp_pkg::DIST_W{1'b0}}, i_distance_scale};
        end
    end

    assign clamped.source = r_prod_src;
    assign clamped.value  = (r_prod > {{rsfp_pkg::SCALE_W{1'b0}}, i_max_distance})
                            ? i_max_distance : r_prod[rsfp_pkg::DIST_W-1:0];

    rsfp_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_prod_valid),
        .i_data  (clamped),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty),
        .o_count (out_count)
    );

endmodule

`default_nettype wire
